// ----- rtl/reed_pkg.sv -----
`timescale 1ns / 1ps

package reed_pkg;

   localparam int EVENT_DEPTH = 8;
   localparam int IDX_W       = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;

   localparam logic [7:0] LOCKOUT_TICKS_RESET = 8'd1;

   localparam logic [2:0] KIND_EDGE_A = 3'd0;
   localparam logic [2:0] KIND_EDGE_B = 3'd1;
   localparam logic [2:0] KIND_TICK   = 3'd2;
   localparam logic [2:0] KIND_BUTTON = 3'd3;
   localparam logic [2:0] KIND_READ   = 3'd4;

   localparam logic [2:0] EV_NONE   = 3'd0;
   localparam logic [2:0] EV_CCW    = 3'd1;
   localparam logic [2:0] EV_CW     = 3'd2;
   localparam logic [2:0] EV_SINGLE = 3'd3;
   localparam logic [2:0] EV_LONG   = 3'd5;

   localparam logic [1:0] BTN_LONG = 2'd2;

   typedef struct packed {
      logic       valid;
      logic [2:0] code;
   } push_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] code;
   } rdout_type;

endpackage

// ----- rtl/rotary_encoder_event_decoder.sv -----
`timescale 1ns / 1ps

// Quadrature encoder event decoder. Words on the req_ channel carry A/B pin
// edges, timer ticks, button events and reads; each read returns exactly one
// rsp_ word with the oldest queued event (or none when the queue is empty).
// One req_ word is taken per clock while req_ready is high. A read is answered
// through the event RAM read register and then the output register.
// req_ready drops only while a read result waits behind an untaken rsp_ word.
// csr_wr_data sets the turn lockout in ticks (0 acts as 1); write it idle.
module rotary_encoder_event_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_kind,
   input  logic       req_pin_level,
   input  logic [1:0] req_button_code,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_event_code,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   import reed_pkg::*;

   logic [7:0] lockout_ticks_ff;
   logic       rsp_valid_ff;
   logic [2:0] rsp_event_code_ff;
   logic       accept;
   logic       stall;
   push_type   push;
   rdout_type  rdout;

   assign stall     = rdout.valid && rsp_valid_ff && !rsp_ready;
   assign req_ready = !stall;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) lockout_ticks_ff <= LOCKOUT_TICKS_RESET;
      else if (csr_wr_en) lockout_ticks_ff <= csr_wr_data;
   end

   reed_event_src u_src (
      .clock        (clock),
      .reset        (reset),
      .item_en      (accept),
      .kind         (req_kind),
      .pin_level    (req_pin_level),
      .button_code  (req_button_code),
      .lockout_ticks(lockout_ticks_ff),
      .push         (push)
   );

   reed_event_store u_store (
      .clock(clock),
      .reset(reset),
      .push (push),
      .rd_en(accept && req_kind == KIND_READ),
      .stall(stall),
      .rdout(rdout)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ready) begin
         rsp_valid_ff <= rdout.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_ready) rsp_event_code_ff <= rdout.code;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_code = rsp_event_code_ff;

   a_read_reaches_stage: assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == KIND_READ |=> rdout.valid)
      else $error("accepted read did not reach the result stage");

   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      stall |=> rdout.valid && $stable(rdout.code))
      else $error("pending read result lost while stalled");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_event_code_ff <= EV_LONG)
      else $error("event code out of range");

endmodule

// ----- rtl/reed_event_src.sv -----
`timescale 1ns / 1ps

module reed_event_src (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_en,
   input  logic [2:0]        kind,
   input  logic              pin_level,
   input  logic [1:0]        button_code,
   input  logic [7:0]        lockout_ticks,
   output reed_pkg::push_type push
);
   import reed_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_P1_0 = 4'd1;
   localparam logic [3:0] ST_P1_1 = 4'd2;
   localparam logic [3:0] ST_P1_2 = 4'd3;
   localparam logic [3:0] ST_P1_3 = 4'd4;
   localparam logic [3:0] ST_P2_0 = 4'd5;
   localparam logic [3:0] ST_P2_1 = 4'd6;
   localparam logic [3:0] ST_P2_2 = 4'd7;
   localparam logic [3:0] ST_P2_3 = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] load_val;
   logic       is_a, is_b, fall, rise;

   assign load_val = (lockout_ticks == 8'd0) ? 8'd1 : lockout_ticks;
   assign is_a     = item_en && (kind == KIND_EDGE_A);
   assign is_b     = item_en && (kind == KIND_EDGE_B);
   assign rise     = pin_level;
   assign fall     = !pin_level;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      push      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (is_a && fall) state_in = ST_P1_0;
            else if (is_b && fall) state_in = ST_P2_0;
         end
         ST_P1_0: if (is_b && fall) state_in = ST_P1_1;
         ST_P1_1: if (is_a && rise) state_in = ST_P1_2;
         ST_P1_2: begin
            if (is_b && rise) begin
               state_in = ST_P1_3;
               count_in = load_val;
            end
         end
         ST_P2_0: if (is_a && fall) state_in = ST_P2_1;
         ST_P2_1: if (is_b && rise) state_in = ST_P2_2;
         ST_P2_2: begin
            if (is_a && rise) begin
               state_in = ST_P2_3;
               count_in = load_val;
            end
         end
         ST_P1_3, ST_P2_3: begin
            if (item_en && kind == KIND_TICK) begin
               if (count_ff > 8'd1) begin
                  count_in = count_ff - 8'd1;
               end else begin
                  count_in   = 8'd0;
                  state_in   = ST_IDLE;
                  push.valid = 1'b1;
                  push.code  = (state_ff == ST_P1_3) ? EV_CCW : EV_CW;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (item_en && kind == KIND_BUTTON && button_code <= BTN_LONG) begin
         push.valid = 1'b1;
         push.code  = EV_SINGLE + {1'b0, button_code};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= 8'd0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/reed_event_store.sv -----
`timescale 1ns / 1ps

module reed_event_store (
   input  logic               clock,
   input  logic               reset,
   input  reed_pkg::push_type push,
   input  logic               rd_en,
   input  logic               stall,
   output reed_pkg::rdout_type rdout
);
   import reed_pkg::*;

   logic [2:0]             mem [EVENT_DEPTH];
   logic [EVENT_DEPTH-1:0] full_ff;
   logic [IDX_W-1:0]       wr_idx_ff;
   logic [IDX_W-1:0]       rd_idx_ff;
   logic [2:0]             rd_data_ff;
   logic                   s1_valid_ff;
   logic                   s1_hit_ff;
   logic                   hit;

   localparam logic [IDX_W-1:0] LAST = IDX_W'(EVENT_DEPTH - 1);

   assign hit = full_ff[rd_idx_ff];

   // entry payload; emptiness is tracked in full_ff
   always_ff @(posedge clock) begin
      if (push.valid) mem[wr_idx_ff] <= push.code;
      if (rd_en) rd_data_ff <= mem[rd_idx_ff];
      if (!stall) s1_hit_ff <= rd_en && hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff     <= '0;
         wr_idx_ff   <= '0;
         rd_idx_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (push.valid) begin
            full_ff[wr_idx_ff] <= 1'b1;
            wr_idx_ff <= (wr_idx_ff == LAST) ? '0 : wr_idx_ff + 1'b1;
         end
         if (rd_en && hit) begin
            full_ff[rd_idx_ff] <= 1'b0;
            rd_idx_ff <= (rd_idx_ff == LAST) ? '0 : rd_idx_ff + 1'b1;
         end
         if (!stall) s1_valid_ff <= rd_en;
      end
   end

   assign rdout.valid = s1_valid_ff;
   assign rdout.code  = s1_hit_ff ? rd_data_ff : EV_NONE;

endmodule
